>>> rtl/core/drbm_pkg.sv
// ----------------------------------------------------------------------------
// drbm_pkg: shared types and constants
// Item layouts, queue entry, register codes and fixed-point constants of the
// delta-R best-match search.
// ----------------------------------------------------------------------------
package drbm_pkg;

  // Azimuth in radians times 2^12
  localparam logic signed [15:0] PHI_PI     = 16'sd12868;
  localparam logic signed [15:0] PHI_NEG_PI = -16'sd12868;
  localparam logic signed [15:0] PHI_TWO_PI = 16'sd25736;

  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  // Configuration register reset values
  localparam logic [30:0] DR2_LIMIT_RST = 31'd671089;
  localparam logic [15:0] PT_FACTOR_RST = 16'd768;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DR2_LIMIT = 1'b0,
    CFG_PT_WINDOW = 1'b1
  } cfg_reg_t;

  // Queue between classification and search
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic first;
    logic last;
    logic valid;
  } item_flags_t;

  typedef struct packed {
    item_flags_t        flags;
    logic        [19:0] obj_pt;
    logic signed [15:0] obj_eta;
    logic signed [14:0] obj_phi;
    logic        [19:0] pt_resolution;
    logic        [19:0] cand_pt;
    logic signed [15:0] cand_eta;
    logic signed [14:0] cand_phi;
  } in_item_t;

  typedef struct packed {
    item_flags_t flags;
    logic [31:0] dr2;
    logic        qual;
  } queue_item_t;

endpackage

>>> rtl/core/drbm_in_if.sv
// ----------------------------------------------------------------------------
// drbm_in_if: candidate item channel
// Valid/ready channel carrying one object/candidate pair per transfer.
// ----------------------------------------------------------------------------
interface drbm_in_if;
  logic               valid;
  logic               ready;
  logic               first_of_search;
  logic               last_of_search;
  logic               cand_valid;
  logic        [19:0] obj_pt;
  logic signed [15:0] obj_eta;
  logic signed [14:0] obj_phi;
  logic        [19:0] pt_resolution;
  logic        [19:0] cand_pt;
  logic signed [15:0] cand_eta;
  logic signed [14:0] cand_phi;

  modport source (
    output valid, first_of_search, last_of_search, cand_valid, obj_pt, obj_eta,
           obj_phi, pt_resolution, cand_pt, cand_eta, cand_phi,
    input  ready
  );
  modport sink (
    input  valid, first_of_search, last_of_search, cand_valid, obj_pt, obj_eta,
           obj_phi, pt_resolution, cand_pt, cand_eta, cand_phi,
    output ready
  );
endinterface

>>> rtl/core/drbm_out_if.sv
// ----------------------------------------------------------------------------
// drbm_out_if: match result channel
// Valid/ready channel carrying one search result per transfer.
// ----------------------------------------------------------------------------
interface drbm_out_if;
  logic       valid;
  logic       ready;
  logic       match_found;
  logic [9:0] match_index;

  modport source (output valid, match_found, match_index, input ready);
  modport sink   (input valid, match_found, match_index, output ready);
endinterface

>>> rtl/core/drbm_cfg_if.sv
// ----------------------------------------------------------------------------
// drbm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface drbm_cfg_if import drbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/drbm_front.sv
// ----------------------------------------------------------------------------
// drbm_front: candidate classifier
// Two-stage pipeline: differences and phi wrap, then squares and pt window
// product; distance sum and cuts feed the queue.
// ----------------------------------------------------------------------------
module drbm_front import drbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  in_item_t    item,
  input  logic [30:0] dr2_limit,
  input  logic [15:0] pt_factor,
  output logic        push,
  output queue_item_t push_item,
  output logic [1:0]  inflight
);

  logic signed [15:0] dphi_raw;
  logic signed [15:0] dphi_wrap;
  logic        [15:0] aphi_full;
  logic signed [16:0] deta_raw;
  logic        [16:0] aeta_full;
  logic        [19:0] dpt;

  logic        s1_vld_r;
  item_flags_t s1_flags_r;
  logic [15:0] s1_aeta_r;
  logic [13:0] s1_aphi_r;
  logic [19:0] s1_dpt_r;
  logic [19:0] s1_res_r;

  logic        s2_vld_r;
  item_flags_t s2_flags_r;
  logic [31:0] s2_eta_sq_r;
  logic [27:0] s2_phi_sq_r;
  logic [27:0] s2_lhs_r;
  logic [35:0] s2_rhs_r;

  logic [32:0] dr2_sum;
  logic [31:0] dr2_val;

  always_comb begin
    dphi_raw = {item.cand_phi[14], item.cand_phi} - {item.obj_phi[14], item.obj_phi};
    // One 2*pi step covers the whole input range
    if (dphi_raw > PHI_PI) begin
      dphi_wrap = dphi_raw - PHI_TWO_PI;
    end else if (dphi_raw < PHI_NEG_PI) begin
      dphi_wrap = dphi_raw + PHI_TWO_PI;
    end else begin
      dphi_wrap = dphi_raw;
    end
    aphi_full = dphi_wrap[15] ? 16'(-dphi_wrap) : 16'(dphi_wrap);

    deta_raw  = {item.cand_eta[15], item.cand_eta} - {item.obj_eta[15], item.obj_eta};
    aeta_full = deta_raw[16] ? 17'(-deta_raw) : 17'(deta_raw);

    dpt = (item.cand_pt >= item.obj_pt) ? (item.cand_pt - item.obj_pt)
                                        : (item.obj_pt - item.cand_pt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= take;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_flags_r  <= item.flags;
    s1_aeta_r   <= aeta_full[15:0];
    s1_aphi_r   <= aphi_full[13:0];
    s1_dpt_r    <= dpt;
    s1_res_r    <= item.pt_resolution;

    s2_flags_r  <= s1_flags_r;
    s2_eta_sq_r <= s1_aeta_r * s1_aeta_r;
    s2_phi_sq_r <= s1_aphi_r * s1_aphi_r;
    s2_lhs_r    <= {s1_dpt_r, 8'd0};
    s2_rhs_r    <= pt_factor * s1_res_r;
  end

  always_comb begin
    dr2_sum = {1'b0, s2_eta_sq_r} + {5'd0, s2_phi_sq_r};
    dr2_val = dr2_sum[32] ? DIST_MAX : dr2_sum[31:0];

    push            = s2_vld_r;
    push_item.flags = s2_flags_r;
    push_item.dr2   = dr2_val;
    push_item.qual  = (dr2_val < {1'b0, dr2_limit}) && ({8'd0, s2_lhs_r} < s2_rhs_r);
    inflight        = {1'b0, s1_vld_r} + {1'b0, s2_vld_r};
  end

endmodule

>>> rtl/core/drbm_queue.sv
// ----------------------------------------------------------------------------
// drbm_queue: classified item queue
// Small register FIFO between the classifier and the search unit.
// ----------------------------------------------------------------------------
module drbm_queue import drbm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  queue_item_t            push_item,
  input  logic                   pop,
  output queue_item_t            head,
  output logic                   nempty,
  output logic [QUEUE_CNT_W-1:0] count
);

  queue_item_t            mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head   = mem_r[rd_ptr_r];
  assign nempty = (count_r != '0);
  assign count  = count_r;

endmodule

>>> rtl/core/drbm_back.sv
// ----------------------------------------------------------------------------
// drbm_back: running-minimum search
// Keeps the best qualifying candidate of the open search and registers the
// result on the last item.
// ----------------------------------------------------------------------------
module drbm_back import drbm_pkg::*; #(
  parameter int MAX_CANDIDATES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_item_t head,
  input  logic        nempty,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        match_found,
  output logic [9:0]  match_index
);

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int POS_W = $clog2(MAX_CANDIDATES);
  localparam int EXT_W = (POS_W > 10) ? POS_W : 10;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);

  logic [31:0]      best_dist_r, best_dist_nxt;
  logic [POS_W-1:0] best_pos_r, best_pos_nxt;
  logic             have_r, have_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic             out_found_r, out_found_nxt;
  logic [9:0]       out_idx_r, out_idx_nxt;

  logic [EXT_W-1:0] pos_ext;

  always_comb begin
    pop = nempty && (!out_vld_r || out_ready);

    best_dist_nxt = best_dist_r;
    best_pos_nxt  = best_pos_r;
    have_nxt      = have_r;
    cnt_nxt       = cnt_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    pos_ext       = '0;

    if (pop) begin
      // Clear first, then evaluate, then report
      if (head.flags.first) begin
        best_dist_nxt = DIST_MAX;
        best_pos_nxt  = '0;
        have_nxt      = 1'b0;
        cnt_nxt       = '0;
      end
      if (head.flags.valid && (cnt_nxt < CNT_MAX)) begin
        if (head.qual && (head.dr2 < best_dist_nxt)) begin
          best_dist_nxt = head.dr2;
          best_pos_nxt  = cnt_nxt[POS_W-1:0];
          have_nxt      = 1'b1;
        end
        cnt_nxt = cnt_nxt + 1'b1;
      end
      pos_ext = EXT_W'(best_pos_nxt);
      if (head.flags.last) begin
        out_vld_nxt   = 1'b1;
        out_found_nxt = have_nxt;
        out_idx_nxt   = have_nxt ? pos_ext[9:0] : 10'd0;
        best_dist_nxt = DIST_MAX;
        best_pos_nxt  = '0;
        have_nxt      = 1'b0;
        cnt_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= DIST_MAX;
      best_pos_r  <= '0;
      have_r      <= 1'b0;
      cnt_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      best_dist_r <= best_dist_nxt;
      best_pos_r  <= best_pos_nxt;
      have_r      <= have_nxt;
      cnt_r       <= cnt_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid   = out_vld_r;
  assign match_found = out_found_r;
  assign match_index = out_idx_r;

endmodule

>>> rtl/core/delta_r_best_match_search_core.sv
// An input transfer passes two classifier stages, a queue slot and the result
// register before its result appears on out_ch. Throughput: one item per cycle
// while in_ch.ready is high; in_ch.ready falls only when the queue plus the
// items in the classifier pipeline reach the queue depth of 4.
// Reset (rst_n low, synchronous): search state cleared, registers back to
// dr2_limit 671089 and pt_window_factor 768, queue and output emptied.
// ----------------------------------------------------------------------------
// delta_r_best_match_search_core: delta-R best-match search
// Streams candidates against one object and reports the closest candidate
// that passes the delta-R and pt window cuts.
// ----------------------------------------------------------------------------
module delta_r_best_match_search_core import drbm_pkg::*; #(
  parameter int MAX_CANDIDATES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  drbm_in_if.sink   in_ch,
  drbm_out_if.source out_ch,
  drbm_cfg_if.sink  cfg_ch
);

  // Configuration registers; the user must write them only while the block is idle (not enforced here)
  logic [30:0] dr2_limit_r;
  logic [15:0] pt_factor_r;

  in_item_t    in_item;
  logic        take;
  logic        push;
  queue_item_t push_item;
  logic [1:0]  inflight;
  queue_item_t head;
  logic        nempty;
  logic        pop;
  logic [QUEUE_CNT_W-1:0] q_count;
  logic [QUEUE_CNT_W-1:0] occupancy;

  // Accept a register write on every cycle
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr2_limit_r <= DR2_LIMIT_RST;
      pt_factor_r <= PT_FACTOR_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_DR2_LIMIT: dr2_limit_r <= cfg_ch.data;
        CFG_PT_WINDOW: pt_factor_r <= cfg_ch.data[15:0];
        default:       dr2_limit_r <= dr2_limit_r;
      endcase
    end
  end

  // Reserve a queue slot for every item still in the classifier, so the
  // pipeline never has to stall and ready never depends on out_ch.ready
  assign occupancy   = q_count + QUEUE_CNT_W'(inflight);
  assign in_ch.ready = (occupancy < QUEUE_CNT_W'(QUEUE_DEPTH));
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    in_item.flags.first  = in_ch.first_of_search;
    in_item.flags.last   = in_ch.last_of_search;
    in_item.flags.valid  = in_ch.cand_valid;
    in_item.obj_pt       = in_ch.obj_pt;
    in_item.obj_eta      = in_ch.obj_eta;
    in_item.obj_phi      = in_ch.obj_phi;
    in_item.pt_resolution = in_ch.pt_resolution;
    in_item.cand_pt      = in_ch.cand_pt;
    in_item.cand_eta     = in_ch.cand_eta;
    in_item.cand_phi     = in_ch.cand_phi;
  end

  // Front: distance and cuts for each transfer
  drbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_item),
    .dr2_limit (dr2_limit_r),
    .pt_factor (pt_factor_r),
    .push      (push),
    .push_item (push_item),
    .inflight  (inflight)
  );

  // Queue: decouple classifier from the search and output stall
  drbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .nempty    (nempty),
    .count     (q_count)
  );

  // Back: running minimum, candidate count and result register
  drbm_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .nempty      (nempty),
    .pop         (pop),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .match_found (out_ch.match_found),
    .match_index (out_ch.match_index)
  );

endmodule
